>>> design/hpsc_pkg.sv
package hpsc_pkg;

    // Field widths.
    localparam int HEADING_W = 12;
    localparam int ERR_W     = 13;
    localparam int RAW_W     = 16;
    localparam int DT_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int INV_W     = 32;
    localparam int INTEG_W   = 64;
    localparam int INC_W     = 30;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ITERM_W   = 48;
    localparam int PSUM_W    = ITERM_W + 1;
    localparam int DFULL_W   = PROD_W - 16;
    localparam int DRIVE_W   = 10;
    localparam int PULSE_W   = 11;
    localparam int LED_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W    = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TI = 2'd2;

    // Configuration reset values.
    localparam logic signed [HEADING_W-1:0] TARGET_RST = 12'sd0;
    localparam logic [GAIN_W-1:0]           GAIN_RST   = 16'd655;
    localparam logic [INV_W-1:0]            INV_TI_RST = 32'd28147;

    // Heading conversion.
    localparam logic [RAW_W-1:0]     HEADING_MAX = 16'd3599;
    localparam logic [HEADING_W-1:0] HALF_TURN   = 12'd1800;
    localparam logic [HEADING_W-1:0] FULL_TURN   = 12'd3600;

    // Drive and pulse.
    localparam int DRIVE_LIMIT = 500;
    localparam logic signed [PULSE_W:0] PULSE_MID = 12'sd1500;
    localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

    // Any PI sum beyond this magnitude saturates the drive for every nonzero gain.
    localparam longint SUM_CLAMP = 64'sd2147483648;

    // LED bands, in tenths of degrees of heading minus target.
    localparam int BAND_FAR  = 1200;
    localparam int BAND_MID  = 600;
    localparam int BAND_NEAR = 5;
    localparam logic [LED_W-1:0] LED_R_FAR  = 4'd1;
    localparam logic [LED_W-1:0] LED_R_MID  = 4'd3;
    localparam logic [LED_W-1:0] LED_R_NEAR = 4'd7;
    localparam logic [LED_W-1:0] LED_L_FAR  = 4'd8;
    localparam logic [LED_W-1:0] LED_L_MID  = 4'd12;
    localparam logic [LED_W-1:0] LED_L_NEAR = 4'd14;
    localparam logic [LED_W-1:0] LED_ON     = 4'd15;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [1:0] {
        MOP_INC,
        MOP_HI,
        MOP_LO,
        MOP_DRIVE
    } t_mul_op;

    typedef enum logic [2:0] {
        DOP_NONE,
        DOP_LOAD,
        DOP_INTEG,
        DOP_SAVE_HI,
        DOP_ITERM,
        DOP_SUM,
        DOP_RESULT
    } t_dp_op;

    typedef enum logic [1:0] {
        C_NONE,
        C_NO_START,
        C_OUT_BUSY,
        C_ALWAYS
    } t_cond;

    typedef struct packed {
        logic    mul_en;
        t_mul_op mul_op;
        t_dp_op  dp_op;
        t_cond   cond;
        t_step   target;
        logic    last;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic out_busy;
    } t_status;

    // Program steps.
    localparam t_step STEP_IDLE   = 4'd0;
    localparam t_step STEP_M_INC  = 4'd1;
    localparam t_step STEP_INTEG  = 4'd2;
    localparam t_step STEP_M_HI   = 4'd3;
    localparam t_step STEP_M_LO   = 4'd4;
    localparam t_step STEP_ITERM  = 4'd5;
    localparam t_step STEP_SUM    = 4'd6;
    localparam t_step STEP_M_DRV  = 4'd7;
    localparam t_step STEP_RESULT = 4'd8;

    localparam t_ctrl CTRL_NOP = '{
        mul_en: 1'b0, mul_op: MOP_INC, dp_op: DOP_NONE,
        cond: C_NONE, target: STEP_IDLE, last: 1'b0
    };

    // Microprogram ROM.
    function automatic t_ctrl uc_word(input t_step s);
        t_ctrl w;
        w = CTRL_NOP;
        unique case (s)
            STEP_IDLE: begin
                w.dp_op  = DOP_LOAD;
                w.cond   = C_NO_START;
                w.target = STEP_IDLE;
            end
            STEP_M_INC: begin
                w.mul_en = 1'b1;
                w.mul_op = MOP_INC;
            end
            STEP_INTEG: begin
                w.dp_op = DOP_INTEG;
            end
            STEP_M_HI: begin
                w.mul_en = 1'b1;
                w.mul_op = MOP_HI;
            end
            STEP_M_LO: begin
                w.mul_en = 1'b1;
                w.mul_op = MOP_LO;
                w.dp_op  = DOP_SAVE_HI;
            end
            STEP_ITERM: begin
                w.dp_op = DOP_ITERM;
            end
            STEP_SUM: begin
                w.dp_op = DOP_SUM;
            end
            STEP_M_DRV: begin
                w.mul_en = 1'b1;
                w.mul_op = MOP_DRIVE;
            end
            STEP_RESULT: begin
                w.dp_op  = DOP_RESULT;
                w.cond   = C_OUT_BUSY;
                w.target = STEP_RESULT;
                w.last   = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> design/hpsc_sequencer.sv
module hpsc_sequencer
    import hpsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_ctrl w_word;
    logic  w_jump;

    assign w_word = uc_word(r_step);
    assign o_ctrl = w_word;

    always_comb begin
        unique case (w_word.cond)
            C_NONE:     w_jump = 1'b0;
            C_NO_START: w_jump = !i_status.start;
            C_OUT_BUSY: w_jump = i_status.out_busy;
            C_ALWAYS:   w_jump = 1'b1;
            default:    w_jump = 1'b1;
        endcase
    end

    always_comb begin
        priority if (w_jump) begin
            n_step = w_word.target;
        end else if (w_word.last) begin
            n_step = STEP_IDLE;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> design/hpsc_datapath.sv
module hpsc_datapath
    import hpsc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctrl                       i_ctrl,
    output t_status                     o_status,
    input  logic signed [HEADING_W-1:0] i_target,
    input  logic [GAIN_W-1:0]           i_gain,
    input  logic [INV_W-1:0]            i_inv_ti,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [RAW_W-1:0]            i_heading_raw,
    input  logic [DT_W-1:0]             i_elapsed_us,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [PULSE_W-1:0]          o_pulse_us,
    output logic [LED_W-1:0]            o_led_pattern,
    output logic signed [HEADING_W-1:0] o_heading_tenths,
    output logic                        o_drive_saturated
);

    logic signed [HEADING_W-1:0] r_pos,   n_pos;
    logic signed [ERR_W-1:0]     r_err,   n_err;
    logic [DT_W-1:0]             r_dt,    n_dt;
    logic signed [INTEG_W-1:0]   r_integ, n_integ;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [INTEG_W-1:0]   r_mhi;
    logic signed [ITERM_W-1:0]   r_iterm;
    logic signed [MUL_W-1:0]     r_sum,   n_sum;
    logic                        r_out_valid;
    logic [PULSE_W-1:0]          r_pulse, n_pulse;
    logic [LED_W-1:0]            r_leds,  n_leds;
    logic                        r_sat,   n_sat;

    logic                        w_start;
    logic                        w_out_free;
    logic                        w_result;
    logic [HEADING_W-1:0]        w_clamped;
    logic signed [MUL_W-1:0]     w_mul_a;
    logic signed [MUL_W-1:0]     w_mul_b;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [INC_W-1:0]     w_inc;
    logic signed [INTEG_W:0]     w_isum;
    logic signed [ITERM_W-1:0]   w_q;
    logic [MUL_W-1:0]            w_lo_sum;
    logic signed [ITERM_W-1:0]   w_iterm;
    logic signed [PSUM_W-1:0]    w_psum;
    logic signed [DFULL_W-1:0]   w_dfull;
    logic signed [DRIVE_W-1:0]   w_drive;
    logic signed [PULSE_W:0]     w_pulse;
    logic signed [ERR_W-1:0]     w_diff;

    // No word is taken while reset is held.
    assign o_in_stall = !i_rst_n || (i_ctrl.dp_op != DOP_LOAD);
    assign w_start    = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_result   = (i_ctrl.dp_op == DOP_RESULT) && w_out_free;

    assign o_status.start    = w_start;
    assign o_status.out_busy = !w_out_free;

    // Heading conversion and error, done as the word is taken.
    assign w_clamped = (i_heading_raw > HEADING_MAX) ? HEADING_MAX[HEADING_W-1:0]
                                                     : i_heading_raw[HEADING_W-1:0];
    always_comb begin
        n_pos = (w_clamped > HALF_TURN) ? $signed(w_clamped - FULL_TURN)
                                        : $signed(w_clamped);
        n_err = {i_target[HEADING_W-1], i_target} - {n_pos[HEADING_W-1], n_pos};
        n_dt  = i_elapsed_us;
    end

    // Shared signed multiplier; the control word picks its operands.
    always_comb begin
        unique case (i_ctrl.mul_op)
            MOP_INC: begin
                w_mul_a = MUL_W'(r_err);
                w_mul_b = $signed({{(MUL_W-DT_W){1'b0}}, r_dt});
            end
            MOP_HI: begin
                w_mul_a = MUL_W'($signed(r_integ[INTEG_W-1:INTEG_W/2]));
                w_mul_b = $signed({1'b0, i_inv_ti});
            end
            MOP_LO: begin
                w_mul_a = $signed({1'b0, r_integ[INTEG_W/2-1:0]});
                w_mul_b = $signed({1'b0, i_inv_ti});
            end
            MOP_DRIVE: begin
                w_mul_a = r_sum;
                w_mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, i_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Saturating integral update.
    assign w_inc  = r_prod[INC_W-1:0];
    assign w_isum = {r_integ[INTEG_W-1], r_integ}
                  + {{(INTEG_W+1-INC_W){w_inc[INC_W-1]}}, w_inc};
    always_comb begin
        if (w_isum[INTEG_W] != w_isum[INTEG_W-1]) begin
            n_integ = w_isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = w_isum[INTEG_W-1:0];
        end
    end

    // Integral term: floor of integral times inverse Ti over 2^48, from two
    // 32-bit partial products.
    assign w_q      = r_mhi[INTEG_W-1:16];
    assign w_lo_sum = {{(MUL_W-16){1'b0}}, r_mhi[15:0]} + {1'b0, r_prod[INTEG_W-1:32]};
    assign w_iterm  = w_q + $signed({{(ITERM_W-17){1'b0}}, w_lo_sum[MUL_W-1:16]});

    // PI sum and its clamp.
    assign w_psum = {{(PSUM_W-ERR_W){r_err[ERR_W-1]}}, r_err} + {r_iterm[ITERM_W-1], r_iterm};
    always_comb begin
        priority if (w_psum > SUM_CLAMP) begin
            n_sum = MUL_W'(SUM_CLAMP);
        end else if (w_psum < -SUM_CLAMP) begin
            n_sum = MUL_W'(-SUM_CLAMP);
        end else begin
            n_sum = w_psum[MUL_W-1:0];
        end
    end

    // Drive, pulse and LED bands.
    assign w_dfull = r_prod[PROD_W-1:16];
    always_comb begin
        n_sat = 1'b1;
        priority if (w_dfull > DRIVE_LIMIT) begin
            w_drive = DRIVE_W'(DRIVE_LIMIT);
        end else if (w_dfull < -DRIVE_LIMIT) begin
            w_drive = DRIVE_W'(-DRIVE_LIMIT);
        end else begin
            w_drive = w_dfull[DRIVE_W-1:0];
            n_sat   = 1'b0;
        end
        w_pulse = PULSE_MID - {{(PULSE_W+1-DRIVE_W){w_drive[DRIVE_W-1]}}, w_drive};
        n_pulse = w_pulse[PULSE_W-1:0];
    end

    assign w_diff = {r_pos[HEADING_W-1], r_pos} - {i_target[HEADING_W-1], i_target};
    always_comb begin
        priority if (w_diff > BAND_FAR) begin
            n_leds = LED_R_FAR;
        end else if (w_diff < -BAND_FAR) begin
            n_leds = LED_L_FAR;
        end else if (w_diff > BAND_MID) begin
            n_leds = LED_R_MID;
        end else if (w_diff < -BAND_MID) begin
            n_leds = LED_L_MID;
        end else if (w_diff > BAND_NEAR) begin
            n_leds = LED_R_NEAR;
        end else if (w_diff < -BAND_NEAR) begin
            n_leds = LED_L_NEAR;
        end else begin
            n_leds = LED_ON;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.dp_op == DOP_INTEG) begin
                r_integ <= n_integ;
            end
            if (w_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_pos <= n_pos;
            r_err <= n_err;
            r_dt  <= n_dt;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.dp_op == DOP_SAVE_HI) begin
            r_mhi <= r_prod[INTEG_W-1:0];
        end
        if (i_ctrl.dp_op == DOP_ITERM) begin
            r_iterm <= w_iterm;
        end
        if (i_ctrl.dp_op == DOP_SUM) begin
            r_sum <= n_sum;
        end
        if (w_result) begin
            r_pulse <= n_pulse;
            r_leds  <= n_leds;
            r_sat   <= n_sat;
            o_heading_tenths <= r_pos;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pulse_us        = r_pulse;
    assign o_led_pattern     = r_leds;
    assign o_drive_saturated = r_sat;

endmodule

>>> design/heading_pi_servo_controller.sv
// Heading PI servo controller. Each input word carries a raw compass reading in
// tenths of a degree and the microseconds elapsed since the previous word; the
// block answers each one with exactly one result word: the servo pulse width
// (1000 to 2000 us), a four-LED band pattern, the converted signed heading and
// a flag that tells whether the PI drive hit its +-500 us limit. The error
// integral is kept across words and starts at zero after reset. Control is a
// nine-step microprogram that runs one shared 33x33 multiplier four times per
// word and takes no new word until the program is done with the previous one;
// the result is loaded into the output register at the last step. The input is
// accepted again as soon as the program is back at its first step, even while
// the previous result still waits on a stalled output; the program then holds
// on its last step until the output register frees up. Configuration (target
// heading, gain, inverse integral time) is written through a separate port that
// is ready whenever reset is released, and should only be changed while the
// block is idle. Neither channel takes a word while reset is held.
module heading_pi_servo_controller
    import hpsc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    // Input words.
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [RAW_W-1:0]            i_heading_raw,
    input  logic [DT_W-1:0]             i_elapsed_us,
    // Result words.
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [PULSE_W-1:0]          o_pulse_us,
    output logic [LED_W-1:0]            o_led_pattern,
    output logic signed [HEADING_W-1:0] o_heading_tenths,
    output logic                        o_drive_saturated
);

    logic signed [HEADING_W-1:0] r_target;
    logic [GAIN_W-1:0]           r_gain;
    logic [INV_W-1:0]            r_inv_ti;
    t_ctrl                       w_ctrl;
    t_status                     w_status;

    // Out of reset the register file never pushes back; writes to an unused
    // index are dropped.
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_gain   <= GAIN_RST;
            r_inv_ti <= INV_TI_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TARGET: r_target <= i_cfg_data[HEADING_W-1:0];
                REG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INV_TI: r_inv_ti <= i_cfg_data[INV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Step counter and microprogram ROM.
    hpsc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Datapath driven by the control word: multiplier, integral, clamps, outputs.
    hpsc_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .o_status          (w_status),
        .i_target          (r_target),
        .i_gain            (r_gain),
        .i_inv_ti          (r_inv_ti),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_heading_raw     (i_heading_raw),
        .i_elapsed_us      (i_elapsed_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_pulse_us        (o_pulse_us),
        .o_led_pattern     (o_led_pattern),
        .o_heading_tenths  (o_heading_tenths),
        .o_drive_saturated (o_drive_saturated)
    );

    // The drive clamp keeps every pulse inside the servo range.
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pulse_us >= PULSE_MIN && o_pulse_us <= PULSE_MAX))
        else $error("pulse width out of range");

    // A saturated drive lands exactly on one end of the pulse range.
    a_sat_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_saturated) |->
        (o_pulse_us == PULSE_MIN || o_pulse_us == PULSE_MAX))
        else $error("saturated drive not at a pulse limit");

    // Only one word is in the program at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again before the program finished");

    // A new result only appears from the result step of the program.
    a_result_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_ctrl.dp_op == DOP_RESULT))
        else $error("result loaded outside the result step");

endmodule
